@@ rtl/stcb_pkg.sv @@
// Shared constants and helper functions for the six-channel timer block.
package stcb_pkg;

    // Channel widths.
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 12;
    localparam int DATA_W   = 32;
    localparam int IRQ_W    = 6;

    // Timer storage widths.
    localparam int CNT_W       = 32;
    localparam int SHORT_CNT_W = 16;
    localparam int EXT_W       = CNT_W + 1;
    localparam int MODE_W      = 16;
    localparam int PHASE_W     = 11;

    // Timer population.
    localparam int MAX_TIMERS    = 6;
    localparam int NUM_TIMERS_DEF = 6;
    localparam int SHORT_TIMERS  = 3;

    // Transaction action codes.
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    // Register offsets within a timer's window.
    localparam logic [3:0] OFF_COUNT  = 4'h0;
    localparam logic [3:0] OFF_MODE   = 4'h4;
    localparam logic [3:0] OFF_TARGET = 4'h8;

    // Window bases of the two timer groups.
    localparam logic [ADDR_W-1:0] BASE_LOW  = 12'h100;
    localparam logic [ADDR_W-1:0] BASE_HIGH = 12'h480;

    // Mode bit positions.
    localparam int MB_RESET  = 3;
    localparam int MB_CMPIRQ = 4;
    localparam int MB_OVFIRQ = 5;
    localparam int MB_REPEAT = 6;
    localparam int MB_TOGGLE = 7;
    localparam int MB_EXTCLK = 8;
    localparam int MB_T2PRE  = 9;
    localparam int MB_IRQEN  = 10;
    localparam int MB_CMPFLG = 11;
    localparam int MB_OVFFLG = 12;
    localparam int MB_T4PRE_LO = 13;
    localparam int MB_T4PRE_HI = 14;

    // Mode write masks: the flags come from the old mode, the enable is forced on, the rest from the bus.
    localparam logic [MODE_W-1:0] MODE_KEEP_MASK = 16'h1c00;
    localparam logic [MODE_W-1:0] MODE_DATA_MASK = 16'he3ff;
    localparam logic [MODE_W-1:0] MODE_IRQEN     = 16'h0400;

    // Counter limits, one bit wider than the counter to see the carry.
    localparam logic [EXT_W-1:0] LIMIT_SHORT = 33'h0_0000_ffff;
    localparam logic [EXT_W-1:0] LIMIT_LONG  = 33'h0_ffff_ffff;

    // Last phase value of each prescaled period (period minus one).
    localparam logic [PHASE_W-1:0] T1_PHASE_LAST = 11'd1171;
    localparam logic [PHASE_W-1:0] T2_PHASE_LAST = 11'd3;
    localparam logic [PHASE_W-1:0] T4_PHASE_LAST = 11'd128;

    // Base address of timer i.
    function automatic logic [ADDR_W-1:0] timer_base(input int i);
        logic [ADDR_W-1:0] base;
        if (i < SHORT_TIMERS)
        begin
            base = BASE_LOW + ADDR_W'(16 * i);
        end
        else
        begin
            base = BASE_HIGH + ADDR_W'(16 * (i - SHORT_TIMERS));
        end
        return base;
    endfunction

    // Last phase value of the prescaler of timer i; zero where there is none.
    function automatic logic [PHASE_W-1:0] phase_last(input int i);
        logic [PHASE_W-1:0] last;
        case (i)
            1:       last = T1_PHASE_LAST;
            2:       last = T2_PHASE_LAST;
            4:       last = T4_PHASE_LAST;
            default: last = '0;
        endcase
        return last;
    endfunction

    // True when timer i runs from its prescaler under mode m.
    function automatic logic prescale_on(input int i, input logic [MODE_W-1:0] m);
        logic on;
        case (i)
            1:       on = m[MB_EXTCLK];
            2:       on = m[MB_T2PRE];
            4:       on = m[MB_T4PRE_LO] | m[MB_T4PRE_HI];
            default: on = 1'b0;
        endcase
        return on;
    endfunction

    // Interrupt enable update when a timer fires.
    function automatic logic [MODE_W-1:0] fire_mode(input logic [MODE_W-1:0] m);
        logic [MODE_W-1:0] r;
        r = m;
        if (!r[MB_REPEAT])
        begin
            r[MB_IRQEN] = 1'b0;
        end
        else if (r[MB_TOGGLE])
        begin
            r[MB_IRQEN] = ~r[MB_IRQEN];
        end
        return r;
    endfunction

endpackage

@@ rtl/stcb_req_if.sv @@
// Request channel interface: tick, bus read or bus write transactions.
interface stcb_req_if;
    logic                               valid;
    logic                               ready;
    logic [stcb_pkg::ACTION_W-1:0]      action;
    logic [stcb_pkg::ADDR_W-1:0]        address;
    logic [stcb_pkg::DATA_W-1:0]        write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink   (input valid, action, address, write_data, output ready);
endinterface

@@ rtl/stcb_rsp_if.sv @@
// Response channel interface: read data and interrupt pulses.
interface stcb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [stcb_pkg::DATA_W-1:0]        read_data;
    logic [stcb_pkg::IRQ_W-1:0]         irq_pulses;

    modport source (output valid, read_data, irq_pulses, input ready);
    modport sink   (input valid, read_data, irq_pulses, output ready);
endinterface

@@ rtl/six_channel_timer_counter_block_core.sv @@
// Top level of the six-channel timer block: timer state, bus decode and response register.
//
//   channel | direction | payload                          | handshake
//   --------+-----------+----------------------------------+------------
//   req     | in        | action, address, write_data      | valid/ready
//   rsp     | out       | read_data, irq_pulses            | valid/ready
//
// Each request transaction is worked in the cycle it is accepted and its response appears
// in the response register on the next cycle; one transaction per cycle unless stalled.
// The figure is set by the per-timer update (33-bit add, target and limit compares).
// Reset clears all counters, targets, modes, prescaler phases and the response valid.
// A stalled response holds; a new request is still taken in the cycle it is drained.
module six_channel_timer_counter_block_core #(
    parameter int NUM_TIMERS = stcb_pkg::NUM_TIMERS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    stcb_req_if.sink        req,
    stcb_rsp_if.source      rsp
);

    localparam int MAXT = stcb_pkg::MAX_TIMERS;

    logic                                   accept;
    logic [3:0]                             offset;
    logic [MAXT-1:0][stcb_pkg::DATA_W-1:0]  rd_vec;
    logic [MAXT-1:0]                        pulse_vec;
    logic [stcb_pkg::DATA_W-1:0]            rd_any;

    logic                                   rsp_valid_reg;
    logic [stcb_pkg::DATA_W-1:0]            read_data_reg;
    logic [stcb_pkg::IRQ_W-1:0]             irq_pulses_reg;

    // Accept whenever the response register is empty or being drained.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign offset    = req.address[3:0];

    // Per-timer state and next-state logic.
    for (genvar i = 0; i < MAXT; i++)
    begin : g_tmr
        if (i < NUM_TIMERS)
        begin : g_on
            localparam int CW = (i < stcb_pkg::SHORT_TIMERS) ?
                                stcb_pkg::SHORT_CNT_W : stcb_pkg::CNT_W;
            localparam logic [stcb_pkg::EXT_W-1:0] LIMIT =
                (i < stcb_pkg::SHORT_TIMERS) ? stcb_pkg::LIMIT_SHORT : stcb_pkg::LIMIT_LONG;
            localparam logic [stcb_pkg::EXT_W-1:0] WRAP = LIMIT + stcb_pkg::EXT_W'(1);
            localparam logic [stcb_pkg::PHASE_W-1:0] PHASE_LAST = stcb_pkg::phase_last(i);
            localparam logic [stcb_pkg::ADDR_W-1:0] BASE = stcb_pkg::timer_base(i);

            logic [CW-1:0]                  count_reg, count_next;
            logic [stcb_pkg::CNT_W-1:0]     target_reg, target_next;
            logic [stcb_pkg::MODE_W-1:0]    mode_reg, mode_next;
            logic [stcb_pkg::PHASE_W-1:0]   phase_reg, phase_next;
            logic                           sel;
            logic [stcb_pkg::DATA_W-1:0]    rd;
            logic                           pulse;

            assign sel = (req.address[stcb_pkg::ADDR_W-1:4] == BASE[stcb_pkg::ADDR_W-1:4]);

            // Tick, read and write effects on this timer.
            always_comb
            begin
                logic [stcb_pkg::EXT_W-1:0]     prev;
                logic [stcb_pkg::EXT_W-1:0]     cnt;
                logic [stcb_pkg::EXT_W-1:0]     tgt;
                logic [stcb_pkg::MODE_W-1:0]    m;
                logic                           pre;
                logic                           cleared;

                count_next  = count_reg;
                target_next = target_reg;
                mode_next   = mode_reg;
                phase_next  = phase_reg;
                rd          = '0;
                pulse       = 1'b0;

                prev    = stcb_pkg::EXT_W'(count_reg);
                tgt     = stcb_pkg::EXT_W'(target_reg);
                pre     = stcb_pkg::prescale_on(i, mode_reg);
                m       = mode_reg;
                cleared = 1'b0;
                cnt     = prev + (pre ? stcb_pkg::EXT_W'(1) : stcb_pkg::EXT_W'(2));

                case (req.action)
                    stcb_pkg::ACT_TICK:
                    begin
                        if (pre && (phase_reg < PHASE_LAST))
                        begin
                            phase_next = phase_reg + stcb_pkg::PHASE_W'(1);
                        end
                        else
                        begin
                            phase_next = '0;
                            // Compare event is handled before overflow.
                            if ((cnt >= tgt) && (prev < tgt))
                            begin
                                m[stcb_pkg::MB_CMPFLG] = 1'b1;
                                if (m[stcb_pkg::MB_CMPIRQ] && m[stcb_pkg::MB_IRQEN])
                                begin
                                    pulse = 1'b1;
                                    m     = stcb_pkg::fire_mode(m);
                                    if (m[stcb_pkg::MB_RESET])
                                    begin
                                        cnt = '0;
                                    end
                                end
                            end
                            // Overflow wraps, or clears on a firing reset-mode timer.
                            if (cnt > LIMIT)
                            begin
                                m[stcb_pkg::MB_OVFFLG] = 1'b1;
                                if (m[stcb_pkg::MB_OVFIRQ] && m[stcb_pkg::MB_IRQEN])
                                begin
                                    pulse   = 1'b1;
                                    m       = stcb_pkg::fire_mode(m);
                                    cleared = m[stcb_pkg::MB_RESET];
                                end
                                cnt = cleared ? '0 : (cnt - WRAP);
                            end
                            count_next = CW'(cnt);
                            mode_next  = m;
                        end
                    end
                    stcb_pkg::ACT_READ:
                    begin
                        if (sel)
                        begin
                            case (offset)
                                stcb_pkg::OFF_COUNT:  rd = stcb_pkg::DATA_W'(count_reg);
                                stcb_pkg::OFF_TARGET: rd = target_reg;
                                stcb_pkg::OFF_MODE:
                                begin
                                    rd = stcb_pkg::DATA_W'(mode_reg);
                                    mode_next[stcb_pkg::MB_CMPFLG] = 1'b0;
                                    mode_next[stcb_pkg::MB_OVFFLG] = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                    end
                    stcb_pkg::ACT_WRITE:
                    begin
                        if (sel)
                        begin
                            case (offset)
                                stcb_pkg::OFF_COUNT:  count_next = CW'(req.write_data);
                                stcb_pkg::OFF_TARGET:
                                begin
                                    target_next = req.write_data;
                                    if (!mode_reg[stcb_pkg::MB_TOGGLE])
                                    begin
                                        mode_next[stcb_pkg::MB_IRQEN] = 1'b1;
                                    end
                                end
                                stcb_pkg::OFF_MODE:
                                begin
                                    mode_next = ((mode_reg | stcb_pkg::MODE_IRQEN)
                                                 & stcb_pkg::MODE_KEEP_MASK)
                                              | (req.write_data[stcb_pkg::MODE_W-1:0]
                                                 & stcb_pkg::MODE_DATA_MASK);
                                    if (target_reg == '0)
                                    begin
                                        mode_next[stcb_pkg::MB_CMPFLG] = 1'b1;
                                    end
                                    count_next = '0;
                                    phase_next = '0;
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end

            // Timer state registers.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    count_reg  <= '0;
                    target_reg <= '0;
                    mode_reg   <= '0;
                    phase_reg  <= '0;
                end
                else if (accept)
                begin
                    count_reg  <= count_next;
                    target_reg <= target_next;
                    mode_reg   <= mode_next;
                    phase_reg  <= phase_next;
                end
            end

            assign rd_vec[i]    = rd;
            assign pulse_vec[i] = pulse;
        end
        else
        begin : g_off
            assign rd_vec[i]    = '0;
            assign pulse_vec[i] = 1'b0;
        end
    end

    // At most one timer is selected, so the read data is an OR over all timers.
    always_comb
    begin
        rd_any = '0;
        for (int k = 0; k < MAXT; k++)
        begin
            rd_any = rd_any | rd_vec[k];
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg  <= rd_any;
            irq_pulses_reg <= pulse_vec;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.irq_pulses = irq_pulses_reg;

endmodule

@@ rtl/stcb_checker.sv @@
// Port-level checker for the six-channel timer block and its bind statement.
module stcb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic [stcb_pkg::ACTION_W-1:0]    req_action,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [stcb_pkg::DATA_W-1:0]      rsp_read_data,
    input logic [stcb_pkg::IRQ_W-1:0]       rsp_irq_pulses
);

    // A stalled response holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_pulses)))
        else $error("stalled response changed");

    // Requests are refused only while a response is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("request refused without a stalled response");

    // A write transaction gives an all-zero response in the next cycle.
    a_write_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_action == stcb_pkg::ACT_WRITE)) |=>
            (rsp_valid && (rsp_read_data == '0) && (rsp_irq_pulses == '0)))
        else $error("write transaction gave a nonzero response");

    // A tick never returns read data; a read never pulses an interrupt.
    a_tick_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_action == stcb_pkg::ACT_TICK)) |=>
            (rsp_valid && (rsp_read_data == '0)))
        else $error("tick transaction returned read data");

    a_read_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_action == stcb_pkg::ACT_READ)) |=>
            (rsp_valid && (rsp_irq_pulses == '0)))
        else $error("read transaction pulsed an interrupt");

endmodule

bind six_channel_timer_counter_block_core stcb_checker u_stcb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_action     (req.action),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_data  (rsp.read_data),
    .rsp_irq_pulses (rsp.irq_pulses)
);

@@ tb/six_channel_timer_counter_block_core_tb.sv @@
// Self-checking testbench for the six-channel timer block: request driver, response checker.
module six_channel_timer_counter_block_core_tb;
    import stcb_pkg::*;

    localparam int TIMER_COUNT = NUM_TIMERS_DEF;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam logic [3:0] OFF_UNUSED = 4'hc;
    localparam logic [ADDR_W-1:0] WINDOW_SPAN = 12'h030;
    localparam int IDLE_HEAVY = 78;
    localparam int IDLE_LIGHT = 20;
    localparam int RANDOM_REQUESTS = 900;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {PH_STEADY, PH_SENDER_GAPS, PH_RECEIVER_STALLS, PH_BOTH} idle_phase_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } timer_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_pulses;
    } timer_rsp_t;

    logic clk;
    logic rst_n;

    stcb_req_if req();
    stcb_rsp_if rsp();

    six_channel_timer_counter_block_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the timer registers.
    logic [CNT_W-1:0]   timer_count  [TIMER_COUNT];
    logic [CNT_W-1:0]   timer_target [TIMER_COUNT];
    logic [MODE_W-1:0]  timer_mode   [TIMER_COUNT];
    logic [PHASE_W-1:0] timer_phase  [TIMER_COUNT];

    timer_req_t pending_requests[$];
    timer_rsp_t expected_responses[$];
    timer_req_t next_request;
    timer_rsp_t seen_response;
    timer_rsp_t wanted_response;

    int offered_count = 0;
    int accepted_count = 0;
    int total_requests = 1;
    int error_count = 0;
    int cycle_count = 0;
    int cycle_limit = 1000000;
    idle_phase_t idle_phase;

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Interrupt enable update on firing; returns whether the counter is to be cleared.
    function automatic logic fire_timer(int t);
        if (!timer_mode[t][MB_REPEAT])
        begin
            timer_mode[t][MB_IRQEN] = 1'b0;
        end
        else if (timer_mode[t][MB_TOGGLE])
        begin
            timer_mode[t][MB_IRQEN] = ~timer_mode[t][MB_IRQEN];
        end
        return timer_mode[t][MB_RESET];
    endfunction

    // Applies one request transaction to the shadow registers and returns its response.
    function automatic timer_rsp_t service_request(timer_req_t rq);
        timer_rsp_t rs;
        int idx;
        int unsigned period;
        int unsigned ph;
        longint unsigned lim;
        longint unsigned prev;
        longint unsigned nxt;
        logic cleared;
        logic [3:0] off;
        logic [MODE_W-1:0] m;
        rs = '0;
        off = rq.address[3:0];
        if (rq.action == ACT_TICK)
        begin
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                period = 1;
                if (t == 1 && timer_mode[t][MB_EXTCLK])
                begin
                    period = T1_PHASE_LAST + 1;
                end
                else if (t == 2 && timer_mode[t][MB_T2PRE])
                begin
                    period = T2_PHASE_LAST + 1;
                end
                else if (t == 4 && timer_mode[t][MB_T4PRE_HI:MB_T4PRE_LO] != 2'b00)
                begin
                    period = T4_PHASE_LAST + 1;
                end

                // Divided clocks only count at the end of their period.
                ph = timer_phase[t] + 1;
                if (ph < period)
                begin
                    timer_phase[t] = PHASE_W'(ph);
                    continue;
                end
                timer_phase[t] = '0;

                lim = (t < SHORT_TIMERS) ? LIMIT_SHORT : LIMIT_LONG;
                prev = timer_count[t];
                nxt = prev + ((period == 1) ? 2 : 1);
                cleared = 1'b0;

                // Compare is handled first; a counter reset here hides the overflow.
                if (nxt >= timer_target[t] && prev < timer_target[t])
                begin
                    timer_mode[t][MB_CMPFLG] = 1'b1;
                    if (timer_mode[t][MB_CMPIRQ] && timer_mode[t][MB_IRQEN])
                    begin
                        rs.irq_pulses[t] = 1'b1;
                        if (fire_timer(t))
                        begin
                            nxt = 0;
                        end
                    end
                end

                if (nxt > lim)
                begin
                    timer_mode[t][MB_OVFFLG] = 1'b1;
                    if (timer_mode[t][MB_OVFIRQ] && timer_mode[t][MB_IRQEN])
                    begin
                        rs.irq_pulses[t] = 1'b1;
                        cleared = fire_timer(t);
                    end
                    nxt = cleared ? 0 : nxt - (lim + 1);
                end
                timer_count[t] = nxt[CNT_W-1:0];
            end
        end
        else if (rq.action == ACT_READ || rq.action == ACT_WRITE)
        begin
            // Address decode: two windows of three timers, three registers each.
            idx = -1;
            if (off == OFF_COUNT || off == OFF_MODE || off == OFF_TARGET)
            begin
                if (rq.address >= BASE_LOW && rq.address < BASE_LOW + WINDOW_SPAN)
                begin
                    idx = int'((rq.address - BASE_LOW) >> 4);
                end
                else if (rq.address >= BASE_HIGH && rq.address < BASE_HIGH + WINDOW_SPAN)
                begin
                    idx = SHORT_TIMERS + int'((rq.address - BASE_HIGH) >> 4);
                end
            end
            if (idx >= TIMER_COUNT)
            begin
                idx = -1;
            end

            if (idx >= 0 && rq.action == ACT_READ)
            begin
                case (off)
                    OFF_COUNT:  rs.read_data = timer_count[idx];
                    OFF_TARGET: rs.read_data = timer_target[idx];
                    default:
                    begin
                        // A mode read clears both event flags.
                        rs.read_data = DATA_W'(timer_mode[idx]);
                        timer_mode[idx][MB_CMPFLG] = 1'b0;
                        timer_mode[idx][MB_OVFFLG] = 1'b0;
                    end
                endcase
            end
            else if (idx >= 0)
            begin
                case (off)
                    OFF_COUNT:
                    begin
                        timer_count[idx] = (idx < SHORT_TIMERS) ?
                            DATA_W'(rq.write_data[SHORT_CNT_W-1:0]) : rq.write_data;
                    end
                    OFF_TARGET:
                    begin
                        timer_target[idx] = rq.write_data;
                        if (!timer_mode[idx][MB_TOGGLE])
                        begin
                            timer_mode[idx][MB_IRQEN] = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Mode write keeps the flags, forces the enable and restarts the count.
                        m = ((timer_mode[idx] | MODE_IRQEN) & MODE_KEEP_MASK)
                            | (rq.write_data[MODE_W-1:0] & MODE_DATA_MASK);
                        timer_count[idx] = '0;
                        timer_phase[idx] = '0;
                        if (!m[MB_TOGGLE])
                        begin
                            m[MB_IRQEN] = 1'b1;
                        end
                        if (timer_target[idx] == '0)
                        begin
                            m[MB_CMPFLG] = 1'b1;
                        end
                        timer_mode[idx] = m;
                    end
                endcase
            end
        end
        return rs;
    endfunction

    // Register address of timer i at the given offset.
    function automatic logic [ADDR_W-1:0] reg_addr(int i, logic [3:0] off);
        logic [ADDR_W-1:0] base;
        if (i < SHORT_TIMERS)
        begin
            base = BASE_LOW + ADDR_W'(16 * i);
        end
        else
        begin
            base = BASE_HIGH + ADDR_W'(16 * (i - SHORT_TIMERS));
        end
        return base | ADDR_W'(off);
    endfunction

    task automatic push_req(logic [ACTION_W-1:0] action, logic [ADDR_W-1:0] address,
                            logic [DATA_W-1:0] data);
        timer_req_t rq;
        rq.action = action;
        rq.address = address;
        rq.write_data = data;
        pending_requests.push_back(rq);
    endtask

    // Idling phase follows the driver's progress through the request list.
    always_comb
    begin
        if (offered_count * 4 >= total_requests * 3)
        begin
            idle_phase = PH_BOTH;
        end
        else if (offered_count * 2 >= total_requests)
        begin
            idle_phase = PH_RECEIVER_STALLS;
        end
        else if (offered_count * 4 >= total_requests)
        begin
            idle_phase = PH_SENDER_GAPS;
        end
        else
        begin
            idle_phase = PH_STEADY;
        end
    end

    // Request driver: presents the next transaction once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req.valid || accepted_count == offered_count)
            begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= ((idle_phase == PH_SENDER_GAPS) ? IDLE_HEAVY :
                                           (idle_phase == PH_BOTH) ? IDLE_LIGHT : 0))
                begin
                    next_request = pending_requests.pop_front();
                    req.valid <= 1'b1;
                    req.action <= next_request.action;
                    req.address <= next_request.address;
                    req.write_data <= next_request.write_data;
                    offered_count++;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Response back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp.ready <= ($urandom_range(99) >= ((idle_phase == PH_RECEIVER_STALLS) ? IDLE_HEAVY :
                                                 (idle_phase == PH_BOTH) ? IDLE_LIGHT : 0));
        end
    end

    // Monitor: check responses against the oldest prediction, predict each accepted request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen_response.read_data = rsp.read_data;
                seen_response.irq_pulses = rsp.irq_pulses;
                if (expected_responses.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected response, expected none, actual read_data %h irq_pulses %b",
                             $time, seen_response.read_data, seen_response.irq_pulses);
                end
                else
                begin
                    wanted_response = expected_responses.pop_front();
                    if (seen_response.read_data !== wanted_response.read_data)
                    begin
                        error_count++;
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, wanted_response.read_data, seen_response.read_data);
                    end
                    if (seen_response.irq_pulses !== wanted_response.irq_pulses)
                    begin
                        error_count++;
                        $display("%0t: irq_pulses mismatch, expected %b, actual %b",
                                 $time, wanted_response.irq_pulses,
                                 seen_response.irq_pulses);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                next_request.action = req.action;
                next_request.address = req.address;
                next_request.write_data = req.write_data;
                expected_responses.push_back(service_request(next_request));
                accepted_count++;
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int tmr;
        int n_ticks;
        int gap;
        int random_goal;
        logic divided;
        logic [DATA_W-1:0] lim;
        logic [DATA_W-1:0] tgt;
        logic [DATA_W-1:0] cnt;
        logic [DATA_W-1:0] upper;
        logic [MODE_W-1:0] m;
        logic [ADDR_W-1:0] a;

        rst_n = 1'b0;
        req.valid = 1'b0;
        req.action = ACT_TICK;
        req.address = '0;
        req.write_data = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            timer_count[i] = '0;
            timer_target[i] = '0;
            timer_mode[i] = '0;
            timer_phase[i] = '0;
        end

        // Directed part: reset values, flag handling, both limits, unmapped accesses.
        push_req(ACT_READ, reg_addr(0, OFF_COUNT), '0);
        push_req(ACT_READ, reg_addr(0, OFF_MODE), '0);
        push_req(ACT_READ, reg_addr(5, OFF_TARGET), '0);
        // Mode write with a zero target raises the compare flag; two reads show and clear it.
        push_req(ACT_WRITE, reg_addr(0, OFF_MODE), 32'h0000_0038);
        push_req(ACT_READ, reg_addr(0, OFF_MODE), '0);
        push_req(ACT_READ, reg_addr(0, OFF_MODE), '0);
        // Short counter keeps 16 bits; a compare with reset hides the overflow.
        push_req(ACT_WRITE, reg_addr(0, OFF_COUNT), 32'hffff_ffff);
        push_req(ACT_WRITE, reg_addr(0, OFF_TARGET), 32'h0001_0000);
        push_req(ACT_TICK, '0, '0);
        // Long counter overflow with reset in repeat mode.
        push_req(ACT_WRITE, reg_addr(3, OFF_MODE), 32'h0000_0068);
        push_req(ACT_WRITE, reg_addr(3, OFF_COUNT), 32'hffff_ffff);
        push_req(ACT_TICK, '0, 32'hffff_ffff);
        push_req(ACT_WRITE, reg_addr(4, OFF_MODE), 32'hffff_ffff);
        // Compare and overflow on the same tick; the toggle turns the enable off in between.
        push_req(ACT_WRITE, reg_addr(5, OFF_MODE), 32'h0000_00f0);
        push_req(ACT_WRITE, reg_addr(5, OFF_COUNT), 32'hffff_fffe);
        push_req(ACT_WRITE, reg_addr(5, OFF_TARGET), 32'hffff_ffff);
        push_req(ACT_TICK, '0, '0);
        push_req(ACT_READ, reg_addr(5, OFF_MODE), '0);
        push_req(ACT_WRITE, reg_addr(0, OFF_UNUSED), 32'hffff_ffff);
        push_req(ACT_READ, 12'hfff, 32'hffff_ffff);
        push_req(ACT_NONE, reg_addr(0, OFF_COUNT), 32'hffff_ffff);
        push_req(ACT_WRITE, reg_addr(TIMER_COUNT, OFF_COUNT), 32'hffff_ffff);
        push_req(ACT_READ, BASE_LOW + WINDOW_SPAN, '0);
        push_req(ACT_READ, reg_addr(3, OFF_TARGET), '0);
        push_req(ACT_READ, reg_addr(4, OFF_MODE), '0);

        // Random part: mostly set-up-and-run sequences on one timer, some raw noise.
        random_goal = pending_requests.size() + RANDOM_REQUESTS;
        while (pending_requests.size() < random_goal)
        begin
            if ($urandom_range(3) == 0)
            begin
                if ($urandom_range(1) == 0)
                begin
                    a = ADDR_W'($urandom);
                end
                else
                begin
                    a = reg_addr($urandom_range(TIMER_COUNT), 4'($urandom_range(3) << 2));
                end
                push_req(ACTION_W'($urandom_range(3)), a, $urandom);
            end
            else
            begin
                tmr = $urandom_range(TIMER_COUNT - 1);
                lim = (tmr < SHORT_TIMERS) ? LIMIT_SHORT[DATA_W-1:0] : LIMIT_LONG[DATA_W-1:0];
                m = MODE_W'($urandom);
                // Divided clocks now and then; timer 1's period is long, so it is rare.
                if (tmr == 1)
                begin
                    m[MB_EXTCLK] = ($urandom_range(29) == 0);
                end
                if (tmr == 2)
                begin
                    m[MB_T2PRE] = ($urandom_range(3) == 0);
                end
                if (tmr == 4)
                begin
                    m[MB_T4PRE_HI:MB_T4PRE_LO] =
                        ($urandom_range(3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
                end
                divided = 1'b1;
                if (tmr == 1 && m[MB_EXTCLK])
                begin
                    n_ticks = T1_PHASE_LAST + 1 + $urandom_range(40);
                end
                else if (tmr == 2 && m[MB_T2PRE])
                begin
                    n_ticks = $urandom_range(4, 24);
                end
                else if (tmr == 4 && m[MB_T4PRE_HI:MB_T4PRE_LO] != 2'b00)
                begin
                    n_ticks = $urandom_range(129, 300);
                end
                else
                begin
                    divided = 1'b0;
                    n_ticks = $urandom_range(1, 12);
                end
                gap = divided ? $urandom_range(4) : $urandom_range(2 * n_ticks + 2);

                case ($urandom_range(7))
                    0:       tgt = '0;
                    1:       tgt = $urandom;
                    default: tgt = $urandom & lim;
                endcase
                // Start either just below the limit or just below the target.
                if ($urandom_range(2) == 0)
                begin
                    cnt = lim - DATA_W'(gap);
                end
                else
                begin
                    cnt = tgt - DATA_W'(gap);
                end
                upper = $urandom;
                if (tmr < SHORT_TIMERS)
                begin
                    cnt = {upper[DATA_W-1:SHORT_CNT_W], cnt[SHORT_CNT_W-1:0]};
                end

                if ($urandom_range(2) == 0)
                begin
                    push_req(ACT_WRITE, reg_addr(tmr, OFF_TARGET), tgt);
                    push_req(ACT_WRITE, reg_addr(tmr, OFF_MODE), {upper[31:16], m});
                end
                else
                begin
                    push_req(ACT_WRITE, reg_addr(tmr, OFF_MODE), {upper[31:16], m});
                    push_req(ACT_WRITE, reg_addr(tmr, OFF_TARGET), tgt);
                end
                push_req(ACT_WRITE, reg_addr(tmr, OFF_COUNT), cnt);
                for (int k = 0; k < n_ticks; k++)
                begin
                    push_req(ACT_TICK, ADDR_W'($urandom), $urandom);
                    if ($urandom_range(4) == 0)
                    begin
                        push_req(ACT_READ, reg_addr(tmr, OFF_MODE), $urandom);
                    end
                end
                push_req(ACT_READ, reg_addr(tmr, OFF_COUNT), $urandom);
                push_req(ACT_READ, reg_addr(tmr, OFF_MODE), $urandom);
                push_req(ACT_READ, reg_addr(tmr, OFF_TARGET), $urandom);
            end
        end
        total_requests = pending_requests.size();
        cycle_limit = total_requests * 40 + 20000;

        // Hold reset, then release it on a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to be taken and answered, then let the block settle.
        while (pending_requests.size() != 0 || req.valid || expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_responses.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/stcb_pkg.sv
rtl/stcb_req_if.sv
rtl/stcb_rsp_if.sv
rtl/six_channel_timer_counter_block_core.sv
rtl/stcb_checker.sv
tb/six_channel_timer_counter_block_core_tb.sv
